// ===== hw/rtl/circle_fan_tessellator_top_assert.svh =====
// Assertion macros for the circle fan tessellator.
// Used by circle_fan_tessellator_top; no other dependencies.
`ifndef CIRCLE_FAN_TESSELLATOR_TOP_ASSERT_SVH
`define CIRCLE_FAN_TESSELLATOR_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define CFT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cft assertion failed");
`define CFT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cft assertion failed");
`else
`define CFT_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define CFT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== hw/rtl/cft_pkg.sv =====
// Shared types, constants and arithmetic helpers of the circle fan tessellator.
// No dependencies.
`default_nettype none
package cft_pkg;

  localparam int unsigned MAX_SEGMENTS_DEF  = 64;
  localparam int unsigned CORDIC_STAGES_DEF = 24;
  // power of two, so the pointers wrap on their own
  localparam int unsigned QUEUE_DEPTH       = 2;

  localparam logic [30:0]        SCALE_RESET = 31'd16777216;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sh026DD3B6A;

  // byte addresses of the scale registers on the configuration port
  localparam logic [2:0] CFG_ADDR_SCALE_X = 3'd0;
  localparam logic [2:0] CFG_ADDR_SCALE_Y = 3'd4;

  typedef struct packed {
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic [23:0]        radius_pixels;
    logic [6:0]         segments;
    logic               end_of_batch;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] apex_x;
    logic signed [31:0] apex_y;
    logic signed [31:0] from_x;
    logic signed [31:0] from_y;
    logic signed [31:0] to_x;
    logic signed [31:0] to_y;
    logic               last_of_fan;
    logic               batch_end;
  } out_beat_t;

  typedef struct packed {
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic [32:0]        rx;
    logic [32:0]        ry;
    logic [6:0]         segs;
    logic               eob;
  } point_t;

  typedef struct packed {
    logic   push;
    point_t data;
  } q_push_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef enum logic [3:0] {
    BK_IDLE, BK_DIV, BK_PREP, BK_STEP, BK_ROT,
    BK_MULX, BK_ADDX, BK_MULY, BK_ADDY, BK_OUT
  } back_state_t;

  // atan(2^-i) in units of 2^-32 turn
  function automatic logic signed [31:0] atan_turn(input logic [4:0] i);
    logic signed [31:0] a;
    unique case (i)
      5'd0:  a = 32'sh20000000;
      5'd1:  a = 32'sh12E4051E;
      5'd2:  a = 32'sh09FB385B;
      5'd3:  a = 32'sh051111D4;
      5'd4:  a = 32'sh028B0D43;
      5'd5:  a = 32'sh0145D7E1;
      5'd6:  a = 32'sh00A2F61E;
      5'd7:  a = 32'sh00517C55;
      5'd8:  a = 32'sh0028BE53;
      5'd9:  a = 32'sh00145F2F;
      5'd10: a = 32'sh000A2F98;
      5'd11: a = 32'sh000517CC;
      5'd12: a = 32'sh00028BE6;
      5'd13: a = 32'sh000145F3;
      5'd14: a = 32'sh0000A2FA;
      5'd15: a = 32'sh0000517D;
      5'd16: a = 32'sh000028BE;
      5'd17: a = 32'sh0000145F;
      5'd18: a = 32'sh00000A30;
      5'd19: a = 32'sh00000518;
      5'd20: a = 32'sh0000028C;
      5'd21: a = 32'sh00000146;
      5'd22: a = 32'sh000000A3;
      5'd23: a = 32'sh00000051;
      5'd24: a = 32'sh00000029;
      5'd25: a = 32'sh00000014;
      5'd26: a = 32'sh0000000A;
      5'd27: a = 32'sh00000005;
      5'd28: a = 32'sh00000003;
      5'd29: a = 32'sh00000001;
      default: a = 32'sh00000000;
    endcase
    return a;
  endfunction

  // round the Q12.12 x Q7.24 product to Q8.24 and clamp at 2^32
  function automatic logic [32:0] clip_radius(input logic [54:0] prod);
    logic [55:0] t;
    t = (56'(prod) + 56'd2048) >> 12;
    if (t > 56'h1_0000_0000) return 33'h1_0000_0000;
    return t[32:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    if (v > 40'sh007FFFFFFF) return 32'sh7FFFFFFF;
    if (v < -40'sh0080000000) return -32'sh80000000;
    return v[31:0];
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/cft_front.sv =====
// Front end: takes points, drops empty fans, clamps segments, forms radii.
// Depends on cft_pkg.
`default_nettype none
module cft_front #(
  parameter int unsigned MAX_SEGMENTS = cft_pkg::MAX_SEGMENTS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire cft_pkg::in_beat_t in_data,
  input  wire logic [30:0]      scale_x,
  input  wire logic [30:0]      scale_y,
  input  wire cft_pkg::q_stat_t q_stat,
  output cft_pkg::q_push_t      q_push
);

  logic              a_v_r;
  cft_pkg::in_beat_t a_r;
  logic              b_v_r;
  logic signed [31:0] b_cx_r, b_cy_r;
  logic [6:0]        b_segs_r;
  logic              b_eob_r;
  logic [54:0]       b_px_r, b_py_r;

  logic       seg_zero, b_free, a_go, accept;
  logic [6:0] seg_c;

  always_comb begin
    seg_c    = (int'(a_r.segments) > MAX_SEGMENTS) ? 7'(MAX_SEGMENTS) : a_r.segments;
    seg_zero = (a_r.segments == 7'd0);
    q_push.push      = b_v_r && !q_stat.full;
    q_push.data.cx   = b_cx_r;
    q_push.data.cy   = b_cy_r;
    q_push.data.rx   = cft_pkg::clip_radius(b_px_r);
    q_push.data.ry   = cft_pkg::clip_radius(b_py_r);
    q_push.data.segs = b_segs_r;
    q_push.data.eob  = b_eob_r;
    b_free   = !b_v_r || q_push.push;
    a_go     = a_v_r && (seg_zero || b_free);
    in_stall = a_v_r && !a_go;
    accept   = in_valid && !in_stall;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
    end else begin
      if (accept) a_v_r <= 1'b1;
      else if (a_go) a_v_r <= 1'b0;
      if (a_go && !seg_zero) b_v_r <= 1'b1;
      else if (q_push.push) b_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) a_r <= in_data;
    if (a_go && !seg_zero) begin
      b_cx_r   <= a_r.center_x;
      b_cy_r   <= a_r.center_y;
      b_segs_r <= seg_c;
      b_eob_r  <= a_r.end_of_batch;
      b_px_r   <= 55'(a_r.radius_pixels) * 55'(scale_x);
      b_py_r   <= 55'(a_r.radius_pixels) * 55'(scale_y);
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/cft_queue.sv =====
// Short point queue between front and back end.
// Depends on cft_pkg.
`default_nettype none
module cft_queue (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire cft_pkg::q_push_t q_push,
  input  wire logic             pop,
  output cft_pkg::point_t       head,
  output cft_pkg::q_stat_t      q_stat
);

  localparam int unsigned PTR_W = (cft_pkg::QUEUE_DEPTH > 1) ? $clog2(cft_pkg::QUEUE_DEPTH) : 1;

  cft_pkg::point_t  q_mem_r [cft_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [PTR_W:0]   count_r;

  always_comb begin
    q_stat.full  = (count_r == (PTR_W+1)'(cft_pkg::QUEUE_DEPTH));
    q_stat.empty = (count_r == '0);
    head         = q_mem_r[rd_ptr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (q_push.push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      if (q_push.push && !pop) count_r <= count_r + 1'b1;
      else if (pop && !q_push.push) count_r <= count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_push.push) q_mem_r[wr_ptr_r] <= q_push.data;
  end

endmodule
`default_nettype wire

// ===== hw/rtl/cft_back.sv =====
// Back end: phase division, iterative CORDIC, radius scaling, triangle output.
// Depends on cft_pkg.
`default_nettype none
module cft_back #(
  parameter int unsigned CORDIC_STAGES = cft_pkg::CORDIC_STAGES_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire cft_pkg::q_stat_t q_stat,
  input  wire cft_pkg::point_t  head,
  output logic                  pop,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output cft_pkg::out_beat_t    out_data
);

  localparam logic [5:0] DIV_LAST = 6'd32;
  localparam logic [5:0] ROT_LAST = 6'(CORDIC_STAGES - 1);

  cft_pkg::back_state_t state_r, state_nxt;
  cft_pkg::point_t      pt_r;
  logic [5:0]           cnt_r;
  logic [6:0]           div_rem_r, racc_r, tri_r;
  logic [31:0]          div_q_r, phase_r;
  logic signed [33:0]   x_r, y_r;
  logic signed [31:0]   z_r;
  logic signed [50:0]   plo_r;
  logic signed [51:0]   phi_r;
  logic signed [31:0]   fx_r, fy_r, tx_r, ty_r;
  logic                 out_v_r;
  cft_pkg::out_beat_t   out_r;

  logic               out_load, last, wrap, axis_y;
  logic [7:0]         trial, racc_sum;
  logic [31:0]        phase_new;
  logic signed [33:0] dx, dy, tsin, tcos, tsel;
  logic [32:0]        rsel;
  logic signed [31:0] csel, rim_val;
  logic signed [67:0] acc;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      cft_pkg::BK_IDLE: if (!q_stat.empty) state_nxt = cft_pkg::BK_DIV;
      cft_pkg::BK_DIV:  if (cnt_r == DIV_LAST) state_nxt = cft_pkg::BK_PREP;
      cft_pkg::BK_PREP: state_nxt = cft_pkg::BK_STEP;
      cft_pkg::BK_STEP: state_nxt = cft_pkg::BK_ROT;
      cft_pkg::BK_ROT:  if (cnt_r == ROT_LAST) state_nxt = cft_pkg::BK_MULX;
      cft_pkg::BK_MULX: state_nxt = cft_pkg::BK_ADDX;
      cft_pkg::BK_ADDX: state_nxt = cft_pkg::BK_MULY;
      cft_pkg::BK_MULY: state_nxt = cft_pkg::BK_ADDY;
      cft_pkg::BK_ADDY: state_nxt = cft_pkg::BK_OUT;
      cft_pkg::BK_OUT:
        if (!out_v_r || !out_stall)
          state_nxt = last ? cft_pkg::BK_IDLE : cft_pkg::BK_STEP;
      default: state_nxt = cft_pkg::BK_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    pop      = (state_r == cft_pkg::BK_IDLE) && !q_stat.empty;
    out_load = (state_r == cft_pkg::BK_OUT) && (!out_v_r || !out_stall);
    axis_y   = (state_r == cft_pkg::BK_MULY) || (state_r == cft_pkg::BK_ADDY);
  end

  // datapath helpers
  always_comb begin
    last      = ({1'b0, tri_r} + 8'd1) == {1'b0, pt_r.segs};
    trial     = {div_rem_r, (cnt_r == 6'd0)};
    racc_sum  = {1'b0, racc_r} + {1'b0, div_rem_r};
    wrap      = racc_sum >= {1'b0, pt_r.segs};
    phase_new = phase_r + div_q_r + 32'(wrap);
    dx        = y_r >>> cnt_r[4:0];
    dy        = x_r >>> cnt_r[4:0];
    case (phase_r[31:30])
      2'd0:    begin tsin = y_r;  tcos = x_r;  end
      2'd1:    begin tsin = x_r;  tcos = -y_r; end
      2'd2:    begin tsin = -y_r; tcos = -x_r; end
      default: begin tsin = -x_r; tcos = y_r;  end
    endcase
    tsel    = axis_y ? tcos : tsin;
    rsel    = axis_y ? pt_r.ry : pt_r.rx;
    csel    = axis_y ? pt_r.cy : pt_r.cx;
    acc     = (68'(phi_r) <<< 16) + 68'(plo_r) + 68'sd536870912;
    rim_val = cft_pkg::sat32(40'(csel) + 40'($signed(acc[67:30])));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cft_pkg::BK_IDLE;
      out_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) out_v_r <= 1'b1;
      else if (!out_stall) out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      cft_pkg::BK_IDLE: begin
        pt_r      <= head;
        cnt_r     <= '0;
        div_rem_r <= '0;
        div_q_r   <= '0;
      end
      cft_pkg::BK_DIV: begin
        // restoring division of 2^32 by the segment count, one bit a cycle
        if (trial >= {1'b0, pt_r.segs}) begin
          div_rem_r <= 7'(trial - {1'b0, pt_r.segs});
          div_q_r   <= {div_q_r[30:0], 1'b1};
        end else begin
          div_rem_r <= trial[6:0];
          div_q_r   <= {div_q_r[30:0], 1'b0};
        end
        cnt_r <= cnt_r + 6'd1;
      end
      cft_pkg::BK_PREP: begin
        fx_r    <= pt_r.cx;
        fy_r    <= cft_pkg::sat32(40'(pt_r.cy) + 40'(pt_r.ry));
        phase_r <= '0;
        racc_r  <= '0;
        tri_r   <= '0;
      end
      cft_pkg::BK_STEP: begin
        phase_r <= phase_new;
        racc_r  <= wrap ? 7'(racc_sum - {1'b0, pt_r.segs}) : racc_sum[6:0];
        x_r     <= cft_pkg::CORDIC_GAIN;
        y_r     <= '0;
        z_r     <= {2'b00, phase_new[29:0]};
        cnt_r   <= '0;
      end
      cft_pkg::BK_ROT: begin
        if (!z_r[31]) begin
          x_r <= x_r - dx;
          y_r <= y_r + dy;
          z_r <= z_r - cft_pkg::atan_turn(cnt_r[4:0]);
        end else begin
          x_r <= x_r + dx;
          y_r <= y_r - dy;
          z_r <= z_r + cft_pkg::atan_turn(cnt_r[4:0]);
        end
        cnt_r <= cnt_r + 6'd1;
      end
      cft_pkg::BK_MULX, cft_pkg::BK_MULY: begin
        plo_r <= $signed({1'b0, rsel[15:0]}) * tsel;
        phi_r <= $signed({1'b0, rsel[32:16]}) * tsel;
      end
      cft_pkg::BK_ADDX: tx_r <= rim_val;
      cft_pkg::BK_ADDY: ty_r <= rim_val;
      cft_pkg::BK_OUT: begin
        if (out_load) begin
          out_r.apex_x      <= pt_r.cx;
          out_r.apex_y      <= pt_r.cy;
          out_r.from_x      <= fx_r;
          out_r.from_y      <= fy_r;
          out_r.to_x        <= tx_r;
          out_r.to_y        <= ty_r;
          out_r.last_of_fan <= last;
          out_r.batch_end   <= last && pt_r.eob;
          fx_r              <= tx_r;
          fy_r              <= ty_r;
          tri_r             <= tri_r + 7'd1;
        end
      end
      default: ;
    endcase
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

// ===== hw/rtl/circle_fan_tessellator_top.sv =====
// Circle fan tessellator top: APB scale registers, front end, queue, back end.
// Each point passes the front registers into the queue, is popped, then gets phase division
// and set-up; each triangle then takes a CORDIC rotation, radius scaling and output.
// Empty fans are dropped in the front end and never reach the queue.
// Reset: synchronous, active low; scales go to 1.0, queue and pipelines empty.
`default_nettype none
`include "circle_fan_tessellator_top_assert.svh"
module circle_fan_tessellator_top #(
  parameter int unsigned MAX_SEGMENTS  = cft_pkg::MAX_SEGMENTS_DEF,
  parameter int unsigned CORDIC_STAGES = cft_pkg::CORDIC_STAGES_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire cft_pkg::in_beat_t in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output cft_pkg::out_beat_t     out_data,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [2:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  // Scale registers: pixel_scale_x at 0x0, pixel_scale_y at 0x4.
  // Decode on address bit 2 only; the low bits are ignored.
  logic [30:0] scale_x_r, scale_y_r;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = paddr[2] ? {1'b0, scale_y_r} : {1'b0, scale_x_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_x_r <= cft_pkg::SCALE_RESET;
      scale_y_r <= cft_pkg::SCALE_RESET;
    end else if (cfg_wr) begin
      // keep the low 31 bits of the beat
      if (paddr[2]) scale_y_r <= pwdata[30:0];
      else          scale_x_r <= pwdata[30:0];
    end
  end

  cft_pkg::q_push_t q_push;
  cft_pkg::q_stat_t q_stat;
  cft_pkg::point_t  head;
  logic             pop;

  // Front: hold the point, drop empty fans, multiply out both radii.
  cft_front #(.MAX_SEGMENTS(MAX_SEGMENTS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .scale_x  (scale_x_r),
    .scale_y  (scale_y_r),
    .q_stat   (q_stat),
    .q_push   (q_push)
  );

  // Queue: decouple the point rate from the triangle rate.
  cft_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_push (q_push),
    .pop    (pop),
    .head   (head),
    .q_stat (q_stat)
  );

  // Back: advance phase, rotate, scale and emit one triangle at a time.
  cft_back #(.CORDIC_STAGES(CORDIC_STAGES)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  `CFT_ASSERT_IMPL(a_batch_on_last, clk, rst_n, out_valid && out_data.batch_end, out_data.last_of_fan)
  `CFT_ASSERT_IMPL(a_no_overflow, clk, rst_n, q_push.push, !q_stat.full)
  `CFT_ASSERT_NEXT(a_scale_x_wr, clk, rst_n, cfg_wr && !paddr[2], scale_x_r == $past(pwdata[30:0]))

endmodule
`default_nettype wire

// ===== tb/circle_fan_tessellator_checker.sv =====
// Watching checker for the circle fan tessellator: predicts every triangle fan
// and compares each result beat. Depends on cft_pkg only.
`timescale 1ns / 1ps
`default_nettype none
module circle_fan_tessellator_checker (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire logic               in_stall,
  input  wire cft_pkg::in_beat_t  in_data,
  input  wire logic               out_valid,
  input  wire logic               out_stall,
  input  wire cft_pkg::out_beat_t out_data,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic               pready,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output int                      mismatches,
  output int                      tris_pending
);

  localparam int         N_STAGES     = cft_pkg::CORDIC_STAGES_DEF;
  localparam int         SEG_CAP      = cft_pkg::MAX_SEGMENTS_DEF;
  localparam longint     K_GAIN       = 64'h26DD3B6A;

  // atan(2^-i) in 2^-32 turn units
  localparam longint ATAN_TURN [30] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
    64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
    64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
    64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
    64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051, 64'h00000029,
    64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000003, 64'h00000001};

  logic [30:0]        scale_x, scale_y;
  cft_pkg::out_beat_t expected_tris[$];

  function automatic longint radius_clip(longint unsigned sz, longint unsigned sc);
    longint unsigned r;
    r = (sz * sc + 64'd2048) >> 12;
    if (r > 64'h1_0000_0000) r = 64'h1_0000_0000;
    return longint'(r);
  endfunction

  function automatic logic [31:0] clamp_q824(longint v);
    if (v > 64'sh7FFFFFFF) return 32'h7FFFFFFF;
    if (v < -64'sh80000000) return 32'h80000000;
    return v[31:0];
  endfunction

  function automatic logic [31:0] rim_coord(longint centre, longint r, longint trig);
    longint off;
    off = (r * trig + (64'sd1 <<< 29)) >>> 30;
    return clamp_q824(centre + off);
  endfunction

  task automatic sin_cos(input logic [31:0] phase, output longint s, output longint c);
    longint x, y, z, dx, dy;
    x = K_GAIN;
    y = 0;
    z = longint'({34'd0, phase[29:0]});
    for (int i = 0; i < N_STAGES && i < 30; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - ATAN_TURN[i];
      end else begin
        x = x + dx; y = y - dy; z = z + ATAN_TURN[i];
      end
    end
    case (phase[31:30])
      2'd0:    begin s = y;  c = x;  end
      2'd1:    begin s = x;  c = -y; end
      2'd2:    begin s = -y; c = -x; end
      default: begin s = -x; c = y;  end
    endcase
  endtask

  // Expand one point into its fan of expected triangles
  task automatic predict_fan(input cft_pkg::in_beat_t p);
    longint cx, cy, rx, ry, s, c;
    longint unsigned ph;
    int segs;
    logic [31:0] fx, fy;
    cft_pkg::out_beat_t t;
    cx = p.center_x;
    cy = p.center_y;
    segs = p.segments;
    if (segs > SEG_CAP) segs = SEG_CAP;
    if (segs == 0) return;
    rx = radius_clip(p.radius_pixels, scale_x);
    ry = radius_clip(p.radius_pixels, scale_y);
    fx = p.center_x;
    fy = clamp_q824(cy + ry);
    for (int j = 0; j < segs; j++) begin
      ph = (longint'(j + 1) << 32) / segs;
      sin_cos(ph[31:0], s, c);
      t.apex_x      = p.center_x;
      t.apex_y      = p.center_y;
      t.from_x      = fx;
      t.from_y      = fy;
      t.to_x        = rim_coord(cx, rx, s);
      t.to_y        = rim_coord(cy, ry, c);
      t.last_of_fan = (j + 1 == segs);
      t.batch_end   = t.last_of_fan & p.end_of_batch;
      expected_tris.push_back(t);
      fx = t.to_x;
      fy = t.to_y;
    end
  endtask

  always @(posedge clk) begin
    cft_pkg::out_beat_t want;
    if (!rst_n) begin
      scale_x = cft_pkg::SCALE_RESET;
      scale_y = cft_pkg::SCALE_RESET;
      expected_tris.delete();
      mismatches = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr == cft_pkg::CFG_ADDR_SCALE_X) scale_x = pwdata[30:0];
        else if (paddr == cft_pkg::CFG_ADDR_SCALE_Y) scale_y = pwdata[30:0];
      end
      if (in_valid && !in_stall) predict_fan(in_data);
      if (out_valid && !out_stall) begin
        if (expected_tris.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected triangle %p", out_data);
        end else begin
          want = expected_tris.pop_front();
          if (out_data !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("triangle mismatch\n  exp %p\n  got %p", want, out_data);
          end
        end
      end
    end
    tris_pending = expected_tris.size();
  end
endmodule
`default_nettype wire

// ===== tb/circle_fan_tessellator_top_tb.sv =====
// Testbench top for the circle fan tessellator: clock, reset, APB scale writes,
// point stimulus and result back-pressure. Depends on cft_pkg and the checker.
`timescale 1ns / 1ps
`default_nettype none
module circle_fan_tessellator_top_tb;

  localparam int         CYCLE_LIMIT  = 3000000;
  localparam int         HOLD_CYCLES  = 400;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  cft_pkg::in_beat_t  in_data;
  logic               out_valid;
  logic               out_stall;
  cft_pkg::out_beat_t out_data;
  logic               psel, penable, pwrite;
  logic [2:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  int  mismatches;
  int  tris_pending;
  int  cycle_count;
  // gaps on both channels; cleared for the closing stretch
  bit  gaps_on;
  // request one long receiver hold-off
  bit  long_hold;

  circle_fan_tessellator_top u_dut (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  circle_fan_tessellator_checker u_checker (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
    .psel, .penable, .pwrite, .pready, .paddr, .pwdata, .mismatches, .tris_pending
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog: abandon the run if the fans never drain
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("circle_fan_tessellator_top_tb: FAIL");
      $finish;
    end
  end

  // Result side back-pressure: short random bursts, plus one long hold-off
  // so the point queue fills and the block stalls its input.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_stall <= 1'b0;
        long_hold = 1'b0;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 3)) @(negedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Two-phase APB write: setup, then access until pready, then back to idle
  task automatic apb_write(input logic [2:0] addr, input logic [31:0] value);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= addr;
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  // Offer one point; hold it until accepted. Called at a falling edge.
  task automatic send_point(input cft_pkg::in_beat_t pt);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= pt;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_fields(input logic [31:0] cx, input logic [31:0] cy,
                             input logic [23:0] rad, input logic [6:0] segs,
                             input logic eob);
    cft_pkg::in_beat_t pt;
    pt.center_x      = cx;
    pt.center_y      = cy;
    pt.radius_pixels = rad;
    pt.segments      = segs;
    pt.end_of_batch  = eob;
    send_point(pt);
  endtask

  // Drain every expected triangle, then let the back end settle before
  // touching the scale registers.
  task automatic drain_and_settle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (tris_pending != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  task automatic set_scales(input logic [31:0] sx, input logic [31:0] sy);
    apb_write(cft_pkg::CFG_ADDR_SCALE_X, sx);
    apb_write(cft_pkg::CFG_ADDR_SCALE_Y, sy);
  endtask

  // Random points: mostly small fans, a few near or beyond the segment cap,
  // with centres and sizes often pushed to the edges.
  task automatic random_points(input int count);
    logic [31:0] cx, cy;
    logic [23:0] rad;
    logic [6:0]  segs;
    for (int n = 0; n < count; n++) begin
      cx = $urandom();
      cy = $urandom();
      if ($urandom_range(0, 7) == 0) cx = $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
      if ($urandom_range(0, 7) == 0) cy = $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
      rad = $urandom();
      case ($urandom_range(0, 3))
        0:       rad = rad >> $urandom_range(8, 23);
        1:       rad = rad >> $urandom_range(0, 7);
        default: ;
      endcase
      if ($urandom_range(0, 19) == 0) segs = $urandom_range(60, 127);
      else segs = $urandom_range(0, 12);
      send_fields(cx, cy, rad, segs, $urandom_range(0, 1));
    end
  endtask

  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    cycle_count = 0;
    gaps_on     = 1'b1;
    long_hold   = 1'b0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed points at reset scales of 1.0
    send_fields(32'h0, 32'h0, 24'h001000, 7'd1, 1'b0);
    send_fields(32'h0, 32'h0, 24'h001000, 7'd2, 1'b0);
    send_fields(32'h01000000, 32'hFF000000, 24'h004800, 7'd3, 1'b1);
    send_fields(32'h12345678, 32'h87654321, 24'h000000, 7'd4, 1'b0);
    send_fields(32'h0, 32'h0, 24'hFFFFFF, 7'd8, 1'b1);        // huge radius, saturate
    send_fields(32'h7FFFFFFF, 32'h7FFFFFFF, 24'h010000, 7'd6, 1'b0);
    send_fields(32'h80000000, 32'h80000000, 24'h010000, 7'd6, 1'b1);
    send_fields(32'h0, 32'h0, 24'h001000, 7'd0, 1'b1);        // empty fan drops its mark
    send_fields(32'h0, 32'h0, 24'h001000, 7'd0, 1'b0);
    send_fields(32'hFFFFFFFF, 32'h00000001, 24'h000001, 7'd64, 1'b1);
    send_fields(32'h00FF00FF, 32'hFF00FF00, 24'h000800, 7'd65, 1'b0); // clamp to cap
    send_fields(32'hAAAAAAAA, 32'h55555555, 24'hAAAAAA, 7'd127, 1'b1);
    send_fields(32'h55555555, 32'hAAAAAAAA, 24'h555555, 7'd5, 1'b0);
    send_fields(32'h7FFFFFFF, 32'h80000000, 24'hFFFFFF, 7'd7, 1'b1);
    drain_and_settle();

    // Extreme scales
    set_scales(32'h0, 32'h7FFFFFFF);
    send_fields(32'h0, 32'h0, 24'hFFFFFF, 7'd4, 1'b1);
    send_fields(32'h0, 32'h0, 24'h000001, 7'd3, 1'b0);
    random_points(40);
    drain_and_settle();

    // Upper bit dropped from a full-width write
    set_scales(32'hFFFFFFFF, 32'h0);
    random_points(40);
    drain_and_settle();

    // Long hold-off: the sender keeps offering while results are blocked
    set_scales(32'h00100000, 32'h00300000);
    long_hold = 1'b1;
    random_points(60);
    drain_and_settle();

    set_scales($urandom(), $urandom());
    random_points(45);
    drain_and_settle();

    // Closing stretch at full rate on both sides
    set_scales(32'h01000000, 32'h00800000);
    gaps_on = 1'b0;
    random_points(50);
    in_valid <= 1'b0;

    @(negedge clk);
    while (tris_pending != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (mismatches == 0 && tris_pending == 0) begin
      $display("circle_fan_tessellator_top_tb: PASS");
    end else begin
      $display("circle_fan_tessellator_top_tb: FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire
